/* sv/assert_macros.svh */
// Assertion macros for the RTL of the dual-ended byte stack; included by the top level.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/tdbs_pkg.sv */
// Package of the dual-ended byte stack: opcodes, size codes and sequencer states.
// No dependencies; imported by the top level and the testbench.
`default_nettype none

package tdbs_pkg;

  typedef enum logic [3:0] {
    OP_PUSH      = 4'd0,
    OP_POP       = 4'd1,
    OP_PEEK      = 4'd2,
    OP_READ_AT   = 4'd3,
    OP_WRITE_AT  = 4'd4,
    OP_GROW      = 4'd5,
    OP_SHRINK    = 4'd6,
    OP_SET_TOP   = 4'd7,
    OP_PUSH_CHAR = 4'd8,
    OP_POP_CHAR  = 4'd9
  } op_t;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

/* sv/tdbs_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies; instantiated once per byte bank by the top level.
`default_nettype none

module tdbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/typed_dual_ended_byte_stack.sv */
// Dual-ended byte stack: main stack growing up, character stack growing down.
// Depends on tdbs_pkg, tdbs_ram and assert_macros.svh.
//
// Usage:
//   Input channel in_*: one transaction carries one operation (opcode, size
//   code, location, value, amount). Output channel out_*: exactly one result
//   transaction per operation, in order. out_tuser is the status bit (1 means
//   a bounds violation or invalid request, with no state changed).
//   Sequence: the block takes the transaction, accesses the four byte-bank
//   RAMs, then assembles the registered read data into the result in the
//   output register. A new operation is taken only after the previous result
//   has left the assemble stage.
//   Stall: a finished result waits in the output register; the next operation
//   is still accepted and executed, and its result holds in the assemble stage
//   (bank read data stays put) until the output register frees up; in_tready
//   stays low meanwhile.
//   Reset: tops go to zero (main) and STORE_BYTES (character); then a clearing
//   pass zeros the store one row of four bytes per cycle, all ceil(STORE_BYTES/4)
//   rows (256 at the default size), with in_tready low throughout.
`default_nettype none
`include "assert_macros.svh"

module typed_dual_ended_byte_stack #(
  parameter int STORE_BYTES = 1024,
  localparam int PTR_W = $clog2(STORE_BYTES + 1),
  localparam int IN_W  = ((2 * PTR_W + 38 + 7) / 8) * 8,
  localparam int OUT_W = ((3 * PTR_W + 32 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // opcode[3:0], size_code[1:0], location, value[31:0], amount; zero fill
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // position, read_value[31:0], main_top, text_top; zero fill
  output logic [OUT_W-1:0] out_tdata,
  // status
  output logic             out_tuser
);

  import tdbs_pkg::*;

  localparam int ROWS  = (STORE_BYTES + 3) / 4;
  localparam int ROW_W = $clog2(ROWS);

  state_t state_r, state_nxt;

  // Captured operation
  logic [3:0]       op_r;
  logic [1:0]       sc_r;
  logic [PTR_W-1:0] loc_r;
  logic [31:0]      val_r;
  logic [PTR_W-1:0] amt_r;

  // Stack tops
  logic [PTR_W-1:0] upper_top_r, upper_top_nxt;
  logic [PTR_W-1:0] lower_top_r, lower_top_nxt;

  // Carried from the execute cycle to the assemble cycle
  logic             fail_r;
  logic [PTR_W-1:0] pos_r;
  logic [1:0]       acc_lo2_r;
  logic [2:0]       wid_r;
  logic             rd_r;

  logic [ROW_W-1:0] clr_cnt_r;

  logic             out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic             out_tuser_r;

  // Execute-cycle decode
  logic             fail;
  logic [PTR_W-1:0] pos;
  logic [PTR_W-1:0] acc_loc;
  logic [2:0]       wid;
  logic [31:0]      wr_val;
  logic             do_rd, do_wr;

  // Bank ports
  logic [3:0]       mem_en, mem_we;
  logic [ROW_W-1:0] mem_addr  [4];
  logic [7:0]       mem_wdata [4];
  logic [7:0]       mem_rdata [4];

  logic [31:0]      rd_val;
  logic             in_fire, out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // Check and decode the held operation against the current tops.
  always_comb begin
    logic [PTR_W:0] up_x, lo_x, loc_x, amt_x, wid_x, sb_x;
    logic [2:0]     sz;
    up_x    = {1'b0, upper_top_r};
    lo_x    = {1'b0, lower_top_r};
    loc_x   = {1'b0, loc_r};
    amt_x   = {1'b0, amt_r};
    sb_x    = (PTR_W + 1)'(STORE_BYTES);
    sz      = (sc_r == SZ_BYTE) ? 3'd1 : (sc_r == SZ_HALF) ? 3'd2 : 3'd4;
    wid_x   = (PTR_W + 1)'(sz);
    fail    = 1'b0;
    pos     = '0;
    acc_loc = '0;
    wid     = sz;
    wr_val  = val_r;
    do_rd   = 1'b0;
    do_wr   = 1'b0;
    upper_top_nxt = upper_top_r;
    lower_top_nxt = lower_top_r;
    unique case (op_r)
      OP_PUSH: begin
        fail          = (up_x + wid_x) > sb_x;
        acc_loc       = upper_top_r;
        pos           = upper_top_r;
        do_wr         = 1'b1;
        upper_top_nxt = PTR_W'(up_x + wid_x);
      end
      OP_POP, OP_PEEK: begin
        fail    = up_x < wid_x;
        acc_loc = PTR_W'(up_x - wid_x);
        pos     = PTR_W'(up_x - wid_x);
        do_rd   = 1'b1;
        if (op_r == OP_POP) begin
          upper_top_nxt = PTR_W'(up_x - wid_x);
        end
      end
      OP_READ_AT, OP_WRITE_AT: begin
        fail    = (loc_x + wid_x) > up_x;
        acc_loc = loc_r;
        pos     = loc_r;
        do_rd   = (op_r == OP_READ_AT);
        do_wr   = (op_r == OP_WRITE_AT);
      end
      OP_GROW: begin
        fail          = (up_x + amt_x) > sb_x;
        upper_top_nxt = PTR_W'(up_x + amt_x);
        pos           = PTR_W'(up_x + amt_x);
      end
      OP_SHRINK: begin
        fail          = up_x < amt_x;
        upper_top_nxt = PTR_W'(up_x - amt_x);
        pos           = PTR_W'(up_x - amt_x);
      end
      OP_SET_TOP: begin
        fail          = loc_x > sb_x;
        upper_top_nxt = loc_r;
        pos           = loc_r;
      end
      OP_PUSH_CHAR: begin
        fail          = (lower_top_r == '0);
        wid           = 3'd1;
        acc_loc       = PTR_W'(lo_x - 1'b1);
        pos           = PTR_W'(lo_x - 1'b1);
        lower_top_nxt = PTR_W'(lo_x - 1'b1);
        do_wr         = 1'b1;
      end
      OP_POP_CHAR: begin
        fail          = lo_x >= sb_x;
        wid           = 3'd1;
        acc_loc       = lower_top_r;
        pos           = PTR_W'(lo_x + 1'b1);
        lower_top_nxt = PTR_W'(lo_x + 1'b1);
        do_rd         = 1'b1;
      end
      default: begin
        fail = 1'b1;
      end
    endcase
    // Sized accesses reject the unused size code.
    if ((op_r <= OP_WRITE_AT) && (sc_r == SZ_BAD)) begin
      fail = 1'b1;
    end
    if (fail) begin
      pos           = '0;
      do_rd         = 1'b0;
      do_wr         = 1'b0;
      upper_top_nxt = upper_top_r;
      lower_top_nxt = lower_top_r;
    end
  end

  // Bank steering: byte i of an access lands in bank (loc+i)&3, and a bank
  // below the start offset takes the next row.
  always_comb begin
    logic [1:0]       off;
    logic [PTR_W-1:0] row;
    for (int b = 0; b < 4; b++) begin
      off = 2'(2'(b) - acc_loc[1:0]);
      row = (acc_loc >> 2) + PTR_W'(2'(b) < acc_loc[1:0]);
      if (state_r == S_CLEAR) begin
        mem_en[b]    = 1'b1;
        mem_we[b]    = 1'b1;
        mem_addr[b]  = clr_cnt_r;
        mem_wdata[b] = '0;
      end else begin
        mem_en[b]    = (state_r == S_EXEC) && (do_rd || do_wr) && ({1'b0, off} < wid);
        mem_we[b]    = do_wr;
        mem_addr[b]  = row[ROW_W-1:0];
        mem_wdata[b] = wr_val[8 * off +: 8];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    tdbs_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk   (clk),
      .en    (mem_en[g]),
      .we    (mem_we[g]),
      .addr  (mem_addr[g]),
      .wdata (mem_wdata[g]),
      .rdata (mem_rdata[g])
    );
  end

  // Reassemble little-endian read data from the banks; drop bytes past width.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < 4; i++) begin
      if (rd_r && (3'(i) < wid_r)) begin
        rd_val[8 * i +: 8] = mem_rdata[2'(acc_lo2_r + 2'(i))];
      end
    end
  end

  always_comb begin
    out_tdata_nxt                            = '0;
    out_tdata_nxt[0 +: PTR_W]                = pos_r;
    out_tdata_nxt[PTR_W +: 32]               = rd_val;
    out_tdata_nxt[PTR_W + 32 +: PTR_W]       = upper_top_r;
    out_tdata_nxt[2 * PTR_W + 32 +: PTR_W]   = lower_top_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  // Sequencer: clear, accept, execute, assemble.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == ROW_W'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      upper_top_r  <= '0;
      lower_top_r  <= PTR_W'(STORE_BYTES);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      // Commit the new tops with the store write.
      if (state_r == S_EXEC) begin
        upper_top_r <= upper_top_nxt;
        lower_top_r <= lower_top_nxt;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_tdata[3:0];
      sc_r  <= in_tdata[5:4];
      loc_r <= in_tdata[6 +: PTR_W];
      val_r <= in_tdata[6 + PTR_W +: 32];
      amt_r <= in_tdata[38 + PTR_W +: PTR_W];
    end
    if (state_r == S_EXEC) begin
      fail_r    <= fail;
      pos_r     <= pos;
      acc_lo2_r <= acc_loc[1:0];
      wid_r     <= wid;
      rd_r      <= do_rd;
    end
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= fail_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `ASSERT_CLK(a_upper_in_range, upper_top_r <= PTR_W'(STORE_BYTES), "main top past store end")
  `ASSERT_CLK(a_lower_in_range, lower_top_r <= PTR_W'(STORE_BYTES), "char top past store end")
  `ASSERT_CLK(a_fail_keeps_tops, (state_r == S_EXEC) && fail |=> $stable(upper_top_r) && $stable(lower_top_r), "failed operation moved a top")
  `ASSERT_NEVER(a_write_outside_op, (|(mem_en & mem_we)) && !(state_r == S_EXEC || state_r == S_CLEAR), "store written outside execute or clear")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for typed_dual_ended_byte_stack: directed and random stack traffic.
// Depends on tdbs_pkg and the RTL of the block. A shadow copy of the store predicts every result.

module tb_top;
  import tdbs_pkg::*;

  localparam int STORE_BYTES = 1024;
  localparam int IN_BITS     = 64;      // opcode..amount packed, zero filled to bytes
  localparam int OUT_BITS    = 72;      // position..text_top packed, zero filled to bytes
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;
  localparam logic [3:0] OP_FIRST_UNDEFINED = 4'd10;

  // One operation, opcode in the lowest bits as on in_tdata.
  typedef struct packed {
    logic [10:0] amount;
    logic [31:0] value;
    logic [10:0] location;
    logic [1:0]  size_code;
    logic [3:0]  opcode;
  } stack_req_t;

  // One result, position in the lowest bits as on out_tdata.
  typedef struct packed {
    logic [10:0] text_top;
    logic [10:0] main_top;
    logic [31:0] read_value;
    logic [10:0] position;
  } stack_rsp_t;

  typedef struct {
    logic [3:0] opcode;
    logic       status;
    stack_rsp_t rsp;
  } stack_result_t;

  // Shadow of the byte store and both tops; predicts one result per operation.
  class stack_shadow;
    logic [7:0]    mem [STORE_BYTES];
    int unsigned   main_top;
    int unsigned   text_top;
    stack_result_t pending_results[$];
    int unsigned   checked;
    int unsigned   rejected;
    int unsigned   failures;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      main_top = 0;
      text_top = STORE_BYTES;
    endfunction

    function logic [31:0] load_bytes(int unsigned at, int unsigned width);
      logic [31:0] word;
      word = '0;
      for (int unsigned i = 0; i < width; i++) word[8*i +: 8] = mem[at + i];
      return word;
    endfunction

    function void store_bytes(int unsigned at, int unsigned width, logic [31:0] word);
      for (int unsigned i = 0; i < width; i++) mem[at + i] = word[8*i +: 8];
    endfunction

    // Apply an accepted operation and queue the result it must produce.
    function void note_op(stack_req_t req);
      stack_result_t res;
      int unsigned   width;
      int unsigned   loc;
      int unsigned   amt;
      bit            fail;
      res.opcode = req.opcode;
      res.rsp    = '0;
      fail       = 1'b0;
      width = (req.size_code == SZ_BYTE) ? 1 : (req.size_code == SZ_HALF) ? 2 : 4;
      loc   = 32'(req.location);
      amt   = 32'(req.amount);
      if (req.opcode <= OP_WRITE_AT && req.size_code == SZ_BAD) begin
        fail = 1'b1;
      end else begin
        case (req.opcode)
          OP_PUSH: begin
            if (main_top + width > STORE_BYTES) fail = 1'b1;
            else begin
              res.rsp.position = 11'(main_top);
              store_bytes(main_top, width, req.value);
              main_top += width;
            end
          end
          OP_POP: begin
            if (main_top < width) fail = 1'b1;
            else begin
              main_top -= width;
              res.rsp.read_value = load_bytes(main_top, width);
              res.rsp.position   = 11'(main_top);
            end
          end
          OP_PEEK: begin
            if (main_top < width) fail = 1'b1;
            else begin
              res.rsp.position   = 11'(main_top - width);
              res.rsp.read_value = load_bytes(main_top - width, width);
            end
          end
          OP_READ_AT: begin
            if (loc + width > main_top) fail = 1'b1;
            else begin
              res.rsp.read_value = load_bytes(loc, width);
              res.rsp.position   = 11'(loc);
            end
          end
          OP_WRITE_AT: begin
            if (loc + width > main_top) fail = 1'b1;
            else begin
              store_bytes(loc, width, req.value);
              res.rsp.position = 11'(loc);
            end
          end
          OP_GROW: begin
            if (main_top + amt > STORE_BYTES) fail = 1'b1;
            else begin
              main_top += amt;
              res.rsp.position = 11'(main_top);
            end
          end
          OP_SHRINK: begin
            if (main_top < amt) fail = 1'b1;
            else begin
              main_top -= amt;
              res.rsp.position = 11'(main_top);
            end
          end
          OP_SET_TOP: begin
            if (loc > STORE_BYTES) fail = 1'b1;
            else begin
              main_top = loc;
              res.rsp.position = 11'(main_top);
            end
          end
          OP_PUSH_CHAR: begin
            if (text_top == 0) fail = 1'b1;
            else begin
              text_top -= 1;
              mem[text_top] = req.value[7:0];
              res.rsp.position = 11'(text_top);
            end
          end
          OP_POP_CHAR: begin
            if (text_top >= STORE_BYTES) fail = 1'b1;
            else begin
              res.rsp.read_value = {24'h0, mem[text_top]};
              text_top += 1;
              res.rsp.position = 11'(text_top);
            end
          end
          default: fail = 1'b1;
        endcase
      end
      if (fail) rejected++;
      res.status       = fail;
      res.rsp.main_top = 11'(main_top);
      res.rsp.text_top = 11'(text_top);
      pending_results.push_back(res);
    endfunction

    // Compare an accepted result with the oldest prediction.
    function void check_result(logic [OUT_BITS-1:0] data, logic status);
      stack_result_t exp_res;
      stack_rsp_t    got;
      got = data[$bits(stack_rsp_t)-1:0];
      checked++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("[%0t] result with no operation pending: status=%0b data=%h",
                   $time, status, data);
        return;
      end
      exp_res = pending_results.pop_front();
      if (status !== exp_res.status || got.position !== exp_res.rsp.position ||
          got.read_value !== exp_res.rsp.read_value ||
          got.main_top !== exp_res.rsp.main_top || got.text_top !== exp_res.rsp.text_top) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("[%0t] mismatch, opcode %0d", $time, exp_res.opcode);
          $display("  expected status=%0b pos=%0d rd=%08h main=%0d text=%0d",
                   exp_res.status, exp_res.rsp.position, exp_res.rsp.read_value,
                   exp_res.rsp.main_top, exp_res.rsp.text_top);
          $display("  actual   status=%0b pos=%0d rd=%08h main=%0d text=%0d",
                   status, got.position, got.read_value, got.main_top, got.text_top);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_BITS-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  logic                out_tuser;

  stack_shadow shadow;
  int unsigned cycle_count = 0;
  int unsigned ops_sent    = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_left     = 0;
  int unsigned rx_mode     = 0;
  int unsigned text_floor  = STORE_BYTES;
  int unsigned random_sent;

  typed_dual_ended_byte_stack #(.STORE_BYTES(STORE_BYTES)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, shadow.pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: alternate open stretches, random chatter and hard stalls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 9);
      if (rx_mode < 3) rx_left = $urandom_range(20, 80);
      else if (rx_mode < 7) rx_left = $urandom_range(20, 60);
      else rx_left = $urandom_range(1, 12);
    end
    rx_left--;
    if (rx_mode < 3) out_tready <= 1'b1;
    else if (rx_mode < 7) out_tready <= 1'($urandom_range(0, 1));
    else out_tready <= 1'b0;
  end

  // Check every result transaction. Values read here are the ones the edge sampled.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_result(out_tdata, out_tuser);
  end

  function automatic stack_req_t make_req(logic [3:0] op, logic [1:0] sc, int unsigned loc,
                                          logic [31:0] val, int unsigned amt);
    stack_req_t req;
    req.opcode    = op;
    req.size_code = sc;
    req.location  = 11'(loc);
    req.value     = val;
    req.amount    = 11'(amt);
    return req;
  endfunction

  // Build a random operation, biased toward requests that pass the bounds checks.
  // With fill_text set, push characters almost always to drive the text end down.
  function automatic stack_req_t random_op(bit fill_text);
    stack_req_t  req;
    int unsigned pick;
    int unsigned knob;
    req.size_code = ($urandom_range(0, 9) == 0) ? SZ_BAD : 2'($urandom_range(0, 2));
    req.location  = 11'($urandom_range(0, 2047));
    req.value     = $urandom;
    req.amount    = 11'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    knob = $urandom_range(0, 9);
    if (fill_text && pick < 90) req.opcode = OP_PUSH_CHAR;
    else if (pick < 18) req.opcode = OP_PUSH;
    else if (pick < 30) req.opcode = OP_POP;
    else if (pick < 38) req.opcode = OP_PEEK;
    else if (pick < 50) req.opcode = OP_READ_AT;
    else if (pick < 62) req.opcode = OP_WRITE_AT;
    else if (pick < 68) req.opcode = OP_GROW;
    else if (pick < 74) req.opcode = OP_SHRINK;
    else if (pick < 79) req.opcode = OP_SET_TOP;
    else if (pick < 89) req.opcode = OP_PUSH_CHAR;
    else if (pick < 96) req.opcode = OP_POP_CHAR;
    else req.opcode = 4'($urandom_range(OP_FIRST_UNDEFINED, 15));
    case (req.opcode)
      OP_READ_AT, OP_WRITE_AT: begin
        // aim inside the live stack, now and then right at its edge
        if (knob < 8 && shadow.main_top > 0)
          req.location = 11'($urandom_range(0, shadow.main_top - 1));
      end
      OP_GROW: begin
        if (knob < 6) req.amount = 11'($urandom_range(0, 48));
        else if (knob < 9) req.amount = 11'($urandom_range(0, STORE_BYTES - shadow.main_top));
      end
      OP_SHRINK: begin
        if (knob < 6) req.amount = 11'($urandom_range(0, 48));
        else if (knob < 9) req.amount = 11'($urandom_range(0, shadow.main_top));
      end
      OP_SET_TOP: begin
        if (knob < 8) req.location = 11'($urandom_range(0, STORE_BYTES));
      end
      default: ;
    endcase
    return req;
  endfunction

  // Present one operation, hold it until accepted, then maybe idle between bursts.
  task automatic send_request(input stack_req_t req);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_BITS - $bits(stack_req_t)){1'b0}}, req};
    do @(posedge clk); while (!in_tready);
    shadow.note_op(req);
    ops_sent++;
    if (shadow.text_top < text_floor) text_floor = shadow.text_top;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // roughly a third of the bursts run straight into the next one
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  initial begin
    shadow    = new();
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty ends, each width, bad decodes, both bounds of the main stack,
    // and a character that lands inside the main stack region.
    send_request(make_req(OP_POP_CHAR, SZ_BYTE, 0, 32'h0, 0));        // text end already empty
    send_request(make_req(OP_POP, SZ_BYTE, 2047, 32'hFFFF_FFFF, 2047)); // main stack empty
    send_request(make_req(OP_PUSH, SZ_WORD, 0, 32'hFFFF_FFFF, 0));
    send_request(make_req(OP_PUSH, SZ_HALF, 0, 32'h0000_A5C3, 0));
    send_request(make_req(OP_PUSH, SZ_BYTE, 0, 32'h0000_0000, 0));
    send_request(make_req(OP_PEEK, SZ_WORD, 0, 32'h0, 0));
    send_request(make_req(OP_READ_AT, SZ_WORD, 0, 32'h0, 0));
    send_request(make_req(OP_WRITE_AT, SZ_BYTE, 3, 32'h1234_5678, 0));
    send_request(make_req(OP_READ_AT, SZ_HALF, 6, 32'h0, 0));           // runs past the top
    send_request(make_req(OP_PUSH, SZ_BAD, 0, 32'hDEAD_BEEF, 0));
    send_request(make_req(4'd15, SZ_BYTE, 0, 32'h0, 0));
    send_request(make_req(OP_FIRST_UNDEFINED, SZ_WORD, 5, 32'h1, 5));
    send_request(make_req(OP_GROW, SZ_BYTE, 0, 32'h0, STORE_BYTES - 7)); // main stack full
    send_request(make_req(OP_PUSH, SZ_BYTE, 0, 32'h55, 0));              // overflow
    send_request(make_req(OP_GROW, SZ_BYTE, 0, 32'h0, 1));
    send_request(make_req(OP_WRITE_AT, SZ_WORD, STORE_BYTES - 4, 32'hCAFE_F00D, 0));
    send_request(make_req(OP_PUSH_CHAR, SZ_BAD, 2047, 32'hFFFF_FFAB, 2047));
    send_request(make_req(OP_READ_AT, SZ_WORD, STORE_BYTES - 4, 32'h0, 0));
    send_request(make_req(OP_POP_CHAR, SZ_BYTE, 0, 32'h0, 0));
    send_request(make_req(OP_SHRINK, SZ_BYTE, 0, 32'h0, STORE_BYTES + 1));
    send_request(make_req(OP_SHRINK, SZ_BYTE, 0, 32'h0, STORE_BYTES));
    send_request(make_req(OP_SET_TOP, SZ_BYTE, STORE_BYTES + 1, 32'h0, 0));
    send_request(make_req(OP_SET_TOP, SZ_BYTE, STORE_BYTES, 32'h0, 0));
    send_request(make_req(OP_SET_TOP, SZ_BYTE, 0, 32'h0, 0));
    send_request(make_req(OP_PEEK, SZ_HALF, 0, 32'h0, 0));
    send_request(make_req(OP_GROW, SZ_BYTE, 0, 32'h0, 2047));

    // Random part: mixed traffic, then walk the text end down to zero and push past it,
    // then mixed traffic again with the two stacks overlapping.
    random_sent = 0;
    repeat (600) begin
      send_request(random_op(1'b0));
      random_sent++;
    end
    while (shadow.text_top > 0) begin
      send_request(random_op(1'b1));
      random_sent++;
    end
    repeat (6) begin
      send_request(random_op(1'b1));
      random_sent++;
    end
    do begin
      send_request(random_op(1'b0));
      random_sent++;
    end while (random_sent < 1950);

    // Drain: wait for every predicted result, then watch for stray results.
    in_tvalid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d operations (%0d rejected by bounds or decode), checked %0d results",
             ops_sent, shadow.rejected, shadow.checked);
    $display("Text end reached %0d; %0d cycles, %0d failures",
             text_floor, cycle_count, shadow.failures);
    if (shadow.failures == 0 && shadow.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/tdbs_pkg.sv
sv/tdbs_ram.sv
sv/typed_dual_ended_byte_stack.sv
tb/tb_top.sv
